// ----- design/sorted_key_table_with_neighbours_core_assert.svh -----
// Assertion macros shared by the sorted key table block.
`ifndef SORTED_KEY_TABLE_WITH_NEIGHBOURS_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_WITH_NEIGHBOURS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SKT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SKT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/skt_pkg.sv -----
// Types and constants shared by the sorted key table block.
package skt_pkg;

    localparam int REQ_BITS  = 3;
    localparam int LINE_BITS = 16;
    localparam int AMT_BITS  = 16;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_TEST   = 3'd2,
        REQ_NEXT   = 3'd3,
        REQ_PREV   = 3'd4,
        REQ_SHIFT  = 3'd5
    } req_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        req_code_t op;
        logic      wr;
    } skt_cmd_t;

endpackage

// ----- design/sorted_key_table_with_neighbours_core.sv -----
// Sorted key table: a row of slot cells with ripple carries and a two-state sequencer.
// Flow: an accepted request moves the sequencer to the execute state, where it is
// worked; its result beat is registered at the end of that state and strobed by done
// for one cycle. No new request is taken while busy in that state, in which every cell
// compares against the broadcast key and the carries ripple along the row.
// Reset clears the entry count, the sequencer and done; stored keys are not reset.
module sorted_key_table_with_neighbours_core
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [REQ_BITS-1:0]         req_type,
    input  logic [LINE_BITS-1:0]        line_number,
    input  logic signed [AMT_BITS-1:0]  shift_amount,
    output logic                        done,
    output logic                        hit,
    output logic [LINE_BITS-1:0]        result_line,
    output logic                        overflow
);

`include "sorted_key_table_with_neighbours_core_assert.svh"

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t                      state_reg;
    state_t                      state_next;
    logic                        exec;
    logic [REQ_BITS-1:0]         req_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic signed [AMT_BITS-1:0]  amt_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    req_code_t                   op;
    logic                        full;
    skt_cmd_t                    cmd;
    logic                        done_reg;
    logic                        hit_reg;
    logic                        hit_next;
    logic [LINE_BITS-1:0]        line_reg;
    logic [LINE_BITS-1:0]        line_next;
    logic                        ovf_reg;
    logic                        ovf_next;

    logic [TABLE_DEPTH-1:0]      occ;
    logic [KEY_BITS-1:0]         key_pad  [0:TABLE_DEPTH+1];
    logic                        fwd_mark [0:TABLE_DEPTH];
    logic [KEY_BITS-1:0]         fwd_data [0:TABLE_DEPTH];
    logic                        bwd_mark [0:TABLE_DEPTH];
    logic [KEY_BITS-1:0]         bwd_data [0:TABLE_DEPTH];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
            ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req_type;
            key_reg <= KEY_BITS'(line_number);
            amt_reg <= shift_amount;
        end
    end

    assign op   = req_code_t'(req_reg);
    assign full = (count_reg == CW'(TABLE_DEPTH));

    assign cmd.op = op;
    assign cmd.wr = exec && !((op == REQ_INSERT) && full);

    // Cell row; the pad entries at both ends feed the outer neighbors.
    assign key_pad[0]             = '0;
    assign key_pad[TABLE_DEPTH+1] = '0;
    assign fwd_mark[0]            = 1'b0;
    assign fwd_data[0]            = '0;
    assign bwd_mark[TABLE_DEPTH]  = 1'b0;
    assign bwd_data[TABLE_DEPTH]  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign occ[i] = (CW'(i) < count_reg);

        skt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk          (clk),
            .cmd          (cmd),
            .key          (key_reg),
            .amt          (amt_reg),
            .occ          (occ[i]),
            .left_key     (key_pad[i]),
            .right_key    (key_pad[i+2]),
            .fwd_mark_in  (fwd_mark[i]),
            .fwd_data_in  (fwd_data[i]),
            .bwd_mark_in  (bwd_mark[i+1]),
            .bwd_data_in  (bwd_data[i+1]),
            .key_q        (key_pad[i+1]),
            .fwd_mark_out (fwd_mark[i+1]),
            .fwd_data_out (fwd_data[i+1]),
            .bwd_mark_out (bwd_mark[i]),
            .bwd_data_out (bwd_data[i])
        );
    end

    // Result and count update, taken at the execute edge.
    always_comb
    begin
        hit_next   = 1'b0;
        line_next  = '0;
        ovf_next   = 1'b0;
        count_next = count_reg;
        case (op)
            REQ_INSERT:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_REMOVE:
            begin
                hit_next = fwd_mark[TABLE_DEPTH];
                if (fwd_mark[TABLE_DEPTH])
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            REQ_TEST, REQ_SHIFT:
            begin
                hit_next = fwd_mark[TABLE_DEPTH];
            end
            REQ_NEXT:
            begin
                hit_next  = fwd_mark[TABLE_DEPTH];
                line_next = LINE_BITS'(fwd_data[TABLE_DEPTH]);
            end
            REQ_PREV:
            begin
                hit_next  = bwd_mark[0];
                line_next = LINE_BITS'(bwd_data[0]);
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            hit_reg  <= hit_next;
            line_reg <= line_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign result_line = line_reg;
    assign overflow    = ovf_reg;

    `SKT_ASSERT_NXT(a_accept_exec, start && !busy, busy, "accepted request did not execute")
    `SKT_ASSERT_NXT(a_exec_done, busy, done && !busy, "execute cycle gave no result beat")
    `SKT_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(TABLE_DEPTH), "entry count too large")
    `SKT_ASSERT_IMP(a_ovf_clean, done && overflow, !hit && (result_line == '0),
                    "overflow beat carries other flags")

endmodule

// ----- design/skt_cell.sv -----
// One table slot: holds a key, compares it with the request and passes carries on.
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS = 16
)
(
    input  logic                       clk,
    input  skt_cmd_t                   cmd,
    input  logic [KEY_BITS-1:0]        key,
    input  logic signed [AMT_BITS-1:0] amt,
    input  logic                       occ,
    input  logic [KEY_BITS-1:0]        left_key,
    input  logic [KEY_BITS-1:0]        right_key,
    input  logic                       fwd_mark_in,
    input  logic [KEY_BITS-1:0]        fwd_data_in,
    input  logic                       bwd_mark_in,
    input  logic [KEY_BITS-1:0]        bwd_data_in,
    output logic [KEY_BITS-1:0]        key_q,
    output logic                       fwd_mark_out,
    output logic [KEY_BITS-1:0]        fwd_data_out,
    output logic                       bwd_mark_out,
    output logic [KEY_BITS-1:0]        bwd_data_out
);

    localparam int SW = ((KEY_BITS > AMT_BITS) ? KEY_BITS : AMT_BITS) + 2;
    localparam logic signed [SW-1:0] KMAX = {{(SW-KEY_BITS){1'b0}}, {KEY_BITS{1'b1}}};

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                gt;
    logic                eq;
    logic                lt;
    logic                ge;
    logic signed [SW-1:0] sum;
    logic [KEY_BITS-1:0] shifted;
    logic                changed;
    logic                mark;
    logic                bmark;
    logic                first;
    logic                last;

    assign gt = occ && (key_reg > key);
    assign eq = occ && (key_reg == key);
    assign lt = occ && (key_reg < key);
    assign ge = occ && !(key_reg < key);

    assign sum = $signed({{(SW-KEY_BITS){1'b0}}, key_reg}) + SW'(amt);

    always_comb
    begin
        if (sum < 0)
        begin
            shifted = '0;
        end
        else if (sum > KMAX)
        begin
            shifted = {KEY_BITS{1'b1}};
        end
        else
        begin
            shifted = KEY_BITS'(sum);
        end
    end

    assign changed = ge && (shifted != key_reg);

    // The forward mark selects the first matching slot, the backward mark the last one.
    always_comb
    begin
        case (cmd.op)
            REQ_INSERT, REQ_NEXT: mark = gt;
            REQ_REMOVE, REQ_TEST: mark = eq;
            REQ_SHIFT:            mark = changed;
            default:              mark = 1'b0;
        endcase
    end

    assign bmark = (cmd.op == REQ_PREV) && lt;

    assign first        = mark && !fwd_mark_in;
    assign fwd_mark_out = fwd_mark_in | mark;
    assign fwd_data_out = fwd_data_in | (first ? key_reg : '0);

    assign last         = bmark && !bwd_mark_in;
    assign bwd_mark_out = bwd_mark_in | bmark;
    assign bwd_data_out = bwd_data_in | (last ? key_reg : '0);

    always_comb
    begin
        key_next = key_reg;
        if (cmd.wr)
        begin
            case (cmd.op)
                REQ_INSERT:
                begin
                    // Slots past the insert point move up by one; the insert point takes the key.
                    if (fwd_mark_in)
                    begin
                        key_next = left_key;
                    end
                    else if (gt || !occ)
                    begin
                        key_next = key;
                    end
                end
                REQ_REMOVE:
                begin
                    if (fwd_mark_in || eq)
                    begin
                        key_next = right_key;
                    end
                end
                REQ_SHIFT:
                begin
                    if (ge)
                    begin
                        key_next = shifted;
                    end
                end
                default:
                begin
                    key_next = key_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule
